FILE: hdl/fssa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fssa_pkg;
   localparam int OFFSET_BITS = 16;

   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_CHECK = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;
   localparam logic [1:0] FIT_NEXT  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_FIT   = 2'd1;
   localparam logic [1:0] ST_NOT_FND  = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic CSR_STRATEGY = 1'b0;
   localparam logic CSR_POOL     = 1'b1;
endpackage
`default_nettype wire

FILE: hdl/fssa_seg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module fssa_seg_ram #(
   parameter int AW = 6,
   parameter int DW = 33
) (
   input  wire logic          clock,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data
);
   logic [DW-1:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: hdl/fit_strategy_segment_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake         | payload
// req     | in  | req_valid/stall   | action, request_size, block_offset
// rsp     | out | rsp_valid/stall   | status, alloc_offset, is_allocated, bytes, holes
// csr     | in  | csr_valid/ready   | csr_index, csr_data
// One request at a time: a scan of the segments plus a decide step, then a shift pass
// for a split or a merge (one entry a cycle through the segment memory) before the
// result is registered and given out.
// Reset and pool writes rebuild entry 0 only; entries beyond the count are never used.
// The result is held in an output register until rsp_stall is low; requests and
// register writes are held off meanwhile.
module fit_strategy_segment_allocator
   import fssa_pkg::*;
#(
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_action,
   input  wire logic [15:0]            req_request_size,
   input  wire logic [15:0]            req_block_offset,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [15:0]                 rsp_alloc_offset,
   output logic                        rsp_is_allocated,
   output logic [15:0]                 rsp_allocated_bytes,
   output logic [6:0]                  rsp_hole_count,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic                   csr_index,
   input  wire logic [15:0]            csr_data
);
   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int OW = OFFSET_BITS;
   localparam int DW = 2 * OW + 1;
   localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_RDK, S_RDN, S_MERGE, S_SHUP, S_SHDN, S_DONE
   } state_type;

   state_type      state_ff;
   logic [1:0]     strat_ff;
   logic [CW-1:0]  count_ff;
   logic [AW-1:0]  cursor_ff;
   logic [OW-1:0]  bytes_ff;
   logic [6:0]     holes_ff;

   logic [1:0]     act_ff;
   logic [OW-1:0]  rsize_ff, roff_ff;
   logic [CW-1:0]  idx_ff;       // read address counter
   logic [CW-1:0]  seen_ff;      // entries examined
   logic [CW-1:0]  rdi_ff;       // index of data arriving this cycle
   logic           rdv_ff;
   logic           hit_ff;
   logic [AW-1:0]  pick_ff;
   logic [OW-1:0]  pstart_ff, psize_ff;
   logic           pused_ff;
   logic           lfree_ff;     // left neighbour free
   logic [OW-1:0]  lsize_ff;
   logic           rfree_ff;
   logic [OW-1:0]  rsize2_ff;
   logic [CW-1:0]  sh_ff;        // shift position
   logic [CW-1:0]  rmcnt_ff;     // entries removed by the merge
   logic [AW-1:0]  shdst_ff;
   logic           shwv_ff;

   logic [1:0]     st_ff;
   logic [OW-1:0]  aoff_ff;
   logic           isal_ff;

   logic [AW-1:0]  rd_addr;
   logic [DW-1:0]  rd_data;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [DW-1:0]  wr_data;

   fssa_seg_ram #(.AW(AW), .DW(DW)) u_ram (
      .clock, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
   );

   logic [OW-1:0] d_start, d_size;
   logic          d_used;
   assign d_start = rd_data[DW-1 -: OW];
   assign d_size  = rd_data[OW:1];
   assign d_used  = rd_data[0];

   logic [CW-1:0] scan_start;
   assign scan_start = (strat_ff == FIT_NEXT && CW'(cursor_ff) < count_ff) ?
                       ((CW'(cursor_ff) + 1'b1 < count_ff) ? CW'(cursor_ff) + 1'b1 : '0) :
                       '0;

   logic fits, better, match;
   assign fits  = !d_used && d_size >= rsize_ff && rsize_ff != '0;
   assign better = !hit_ff || (strat_ff == FIT_BEST && d_size < psize_ff) ||
                   (strat_ff == FIT_WORST && d_size > psize_ff);
   assign match = d_start == roff_ff;

   logic [CW-1:0] idx_nx;
   assign idx_nx = (idx_ff + 1'b1 < count_ff) ? idx_ff + 1'b1 : '0;

   function automatic logic hit_or_done();
      hit_or_done = hit_ff && (act_ff != ACT_ALLOC || strat_ff == FIT_FIRST ||
                    strat_ff == FIT_NEXT);
   endfunction

   assign csr_ready = state_ff == S_IDLE && !rsp_valid;
   assign req_stall = !(state_ff == S_IDLE && !rsp_valid && !csr_valid);
   assign rsp_status = st_ff;
   assign rsp_alloc_offset = aoff_ff;
   assign rsp_is_allocated = isal_ff;
   assign rsp_allocated_bytes = bytes_ff;
   assign rsp_hole_count = holes_ff;

   always_comb begin
      rd_addr = idx_ff[AW-1:0];
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      if (reset) begin
         // entry 0 covers the whole default pool
         wr_en = 1'b1;
         wr_data = {OW'(0), {OW{1'b1}}, 1'b0};
      end else if (state_ff == S_IDLE && csr_valid && csr_ready && csr_index == CSR_POOL) begin
         wr_en = 1'b1;
         wr_data = {OW'(0), csr_data[OW-1:0], 1'b0};
      end else if (shwv_ff) begin
         wr_en = 1'b1;
         wr_addr = shdst_ff;
         wr_data = rd_data;
      end else if (state_ff == S_DONE && act_ff == ACT_ALLOC && st_ff == ST_OK) begin
         wr_en = 1'b1;
         wr_addr = pick_ff;
         wr_data = {pstart_ff, rsize_ff, 1'b1};
      end else if (state_ff == S_DONE && act_ff == ACT_FREE && st_ff == ST_OK && pused_ff) begin
         wr_en = 1'b1;
         wr_addr = lfree_ff ? pick_ff - 1'b1 : pick_ff;
         wr_data = {lfree_ff ? pstart_ff - lsize_ff : pstart_ff,
                    psize_ff + (lfree_ff ? lsize_ff : '0) + (rfree_ff ? rsize2_ff : '0),
                    1'b0};
      end else if (state_ff == S_SHUP && sh_ff == CW'(pick_ff) + 1'b1) begin
         wr_en = 1'b1;
         wr_addr = sh_ff[AW-1:0];
         wr_data = {pstart_ff + rsize_ff, psize_ff - rsize_ff, 1'b0};
      end
      if (state_ff == S_SHUP) rd_addr = sh_ff[AW-1:0] - 1'b1;
      if (state_ff == S_SHDN) rd_addr = sh_ff[AW-1:0];
      if (state_ff == S_RDK || state_ff == S_RDN) rd_addr = idx_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         strat_ff <= FIT_FIRST;
         count_ff <= CW'(1);
         cursor_ff <= '0;
         bytes_ff <= '0;
         holes_ff <= 7'd1;
         rsp_valid <= 1'b0;
         shwv_ff <= 1'b0;
         rdv_ff <= 1'b0;
         st_ff <= ST_OK;
         aoff_ff <= '0;
         isal_ff <= 1'b0;
      end else begin
         shwv_ff <= 1'b0;
         rdv_ff <= 1'b0;
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (csr_valid && csr_ready) begin
                  if (csr_index == CSR_STRATEGY) begin
                     strat_ff <= csr_data[1:0];
                  end else begin
                     count_ff <= CW'(1);
                     cursor_ff <= '0;
                     bytes_ff <= '0;
                     holes_ff <= 7'd1;
                  end
               end else if (req_valid && !req_stall) begin
                  act_ff <= req_action;
                  rsize_ff <= req_request_size;
                  roff_ff <= req_block_offset;
                  hit_ff <= 1'b0;
                  pused_ff <= 1'b0;
                  lfree_ff <= 1'b0;
                  rfree_ff <= 1'b0;
                  idx_ff <= scan_start;
                  rdi_ff <= scan_start;
                  seen_ff <= '0;
                  st_ff <= ST_OK;
                  aoff_ff <= '0;
                  isal_ff <= 1'b0;
                  if (req_action == ACT_ALLOC || req_action == ACT_FREE ||
                      req_action == ACT_CHECK) begin
                     state_ff <= S_SCAN;
                  end else begin
                     rsp_valid <= 1'b1;
                  end
               end
            end
            S_SCAN: begin
               // issue reads; data for rdi_ff arrives from the registered read port on the next cycle
               if (seen_ff < count_ff && !hit_or_done()) begin
                  rdv_ff <= 1'b1;
                  rdi_ff <= idx_ff;
                  idx_ff <= idx_nx;
                  seen_ff <= seen_ff + 1'b1;
               end
               if (rdv_ff) begin
                  if (act_ff == ACT_ALLOC) begin
                     if (fits && better) begin
                        hit_ff <= 1'b1;
                        pick_ff <= rdi_ff[AW-1:0];
                        pstart_ff <= d_start;
                        psize_ff <= d_size;
                     end
                  end else if (match && !hit_ff) begin
                     hit_ff <= 1'b1;
                     pick_ff <= rdi_ff[AW-1:0];
                     pstart_ff <= d_start;
                     psize_ff <= d_size;
                     pused_ff <= d_used;
                  end
               end
               if ((seen_ff == count_ff || hit_or_done()) && !rdv_ff) state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (!hit_ff) begin
                  st_ff <= (act_ff == ACT_ALLOC) ? ST_NO_FIT : ST_NOT_FND;
                  state_ff <= S_DONE;
               end else if (act_ff == ACT_CHECK) begin
                  isal_ff <= pused_ff;
                  state_ff <= S_DONE;
               end else if (act_ff == ACT_ALLOC) begin
                  if (psize_ff == rsize_ff) begin
                     holes_ff <= holes_ff - 1'b1;
                     bytes_ff <= bytes_ff + rsize_ff;
                     cursor_ff <= pick_ff;
                     aoff_ff <= pstart_ff;
                     state_ff <= S_DONE;
                  end else if (count_ff >= MAXC) begin
                     st_ff <= ST_FULL;
                     state_ff <= S_DONE;
                  end else begin
                     bytes_ff <= bytes_ff + rsize_ff;
                     cursor_ff <= pick_ff;
                     aoff_ff <= pstart_ff;
                     sh_ff <= count_ff;
                     state_ff <= S_SHUP;
                  end
               end else if (!pused_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  bytes_ff <= bytes_ff - psize_ff;
                  // no left neighbour at entry 0: go straight to the right one
                  idx_ff <= (pick_ff != '0) ? CW'(pick_ff) - 1'b1 : CW'(pick_ff) + 1'b1;
                  state_ff <= (pick_ff != '0) ? S_RDK : S_RDN;
               end
            end
            S_RDK: begin
               idx_ff <= CW'(pick_ff) + 1'b1;
               state_ff <= S_RDN;
            end
            S_RDN: begin
               if (pick_ff != '0) begin
                  lfree_ff <= !d_used;
                  lsize_ff <= d_size;
               end
               state_ff <= S_MERGE;
            end
            S_MERGE: begin
               rfree_ff <= (CW'(pick_ff) + 1'b1 < count_ff) && !d_used;
               rsize2_ff <= d_size;
               state_ff <= S_SHDN;
               sh_ff <= '0;
               rmcnt_ff <= '0;
            end
            S_SHDN: begin
               // first step: work out removals; then copy entries down
               if (sh_ff == '0 && rmcnt_ff == '0) begin
                  rmcnt_ff <= CW'(lfree_ff) + CW'(rfree_ff);
                  sh_ff <= CW'(pick_ff) + 1'b1 + CW'(rfree_ff);
                  holes_ff <= holes_ff + 1'b1 - 7'(lfree_ff) - 7'(rfree_ff);
                  if (!lfree_ff && !rfree_ff) state_ff <= S_DONE;
                  if (lfree_ff && cursor_ff >= pick_ff && cursor_ff != '0)
                     cursor_ff <= cursor_ff - 1'b1;
                  else if (rfree_ff && cursor_ff >= pick_ff + 1'b1)
                     cursor_ff <= cursor_ff - 1'b1;
                  if (lfree_ff && rfree_ff && cursor_ff >= pick_ff && cursor_ff != '0
                      && cursor_ff - 1'b1 >= pick_ff && cursor_ff - 1'b1 != '0)
                     cursor_ff <= cursor_ff - 2'd2;
               end else if (sh_ff < count_ff) begin
                  shwv_ff <= 1'b1;
                  shdst_ff <= sh_ff[AW-1:0] - rmcnt_ff[AW-1:0];
                  sh_ff <= sh_ff + 1'b1;
               end else if (!shwv_ff) begin
                  count_ff <= count_ff - rmcnt_ff;
                  state_ff <= S_DONE;
               end
            end
            S_SHUP: begin
               // move entries k+1..count-1 up by one, top first
               if (sh_ff > CW'(pick_ff) + 1'b1) begin
                  shwv_ff <= 1'b1;
                  shdst_ff <= sh_ff[AW-1:0];
                  sh_ff <= sh_ff - 1'b1;
               end else if (!shwv_ff) begin
                  count_ff <= count_ff + 1'b1;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               rsp_valid <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= MAXC) else $error("segment count out of range");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("request taken while busy");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_DONE || $past(state_ff) == S_IDLE)
      else $error("result raised outside completion");
   a_holes_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(holes_ff) <= count_ff) else $error("more holes than segments");
`endif
endmodule
`default_nettype wire

FILE: tb/fit_strategy_segment_allocator_tb.sv
`timescale 1ns / 1ps
module fit_strategy_segment_allocator_tb;
   import fssa_pkg::*;

   localparam int SEGS = 64;
   localparam int WATCHDOG = 20000;
   localparam int N_RANDOM = 960;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] alloc_offset;
      logic        is_allocated;
      logic [15:0] allocated_bytes;
      logic [6:0]  hole_count;
   } outcome_t;

   // directed row: action, size, offset, known-result flag, known result
   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] size;
      logic [15:0] offset;
      logic        known;
      outcome_t    result;
   } row_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_action = '0;
   logic [15:0] req_request_size = '0;
   logic [15:0] req_block_offset = '0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic [1:0] rsp_status;
   logic [15:0] rsp_alloc_offset;
   logic rsp_is_allocated;
   logic [15:0] rsp_allocated_bytes;
   logic [6:0] rsp_hole_count;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_index = CSR_STRATEGY;
   logic [15:0] csr_data = '0;

   fit_strategy_segment_allocator u_dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // allocator mirror
   logic [1:0]  strategy;
   logic [15:0] pool_bytes;
   logic [15:0] seg_start [SEGS];
   logic [15:0] seg_size [SEGS];
   logic        seg_used [SEGS];
   int          seg_count, cursor;
   logic [15:0] used_bytes;
   logic [6:0]  holes;

   outcome_t pending_results [$];
   int errors = 0, accepted_reqs = 0, results_seen = 0, idle_cycles = 0;
   bit hold_off = 0;

   function automatic void rebuild_pool();
      for (int i = 0; i < SEGS; i++) begin
         seg_start[i] = '0;
         seg_size[i] = '0;
         seg_used[i] = 0;
      end
      seg_size[0] = pool_bytes;
      seg_count = 1;
      cursor = 0;
      used_bytes = '0;
      holes = 7'd1;
   endfunction

   function automatic bit suits(int i, logic [15:0] req);
      return !seg_used[i] && seg_size[i] >= req;
   endfunction

   function automatic int choose_segment(logic [15:0] req);
      int pick, i;
      pick = seg_count;
      if (strategy == FIT_NEXT) begin
         i = (cursor < seg_count) ? cursor : 0;
         for (int n = 0; n < seg_count; n++) begin
            i = (i + 1 < seg_count) ? i + 1 : 0;
            if (suits(i, req)) return i;
         end
         return seg_count;
      end
      for (i = 0; i < seg_count; i++) begin
         if (!suits(i, req)) continue;
         if (strategy == FIT_FIRST) return i;
         if (pick == seg_count ||
             (strategy == FIT_BEST && seg_size[i] < seg_size[pick]) ||
             (strategy == FIT_WORST && seg_size[i] > seg_size[pick]))
            pick = i;
      end
      return pick;
   endfunction

   function automatic void drop_segment(int k);
      for (int i = k; i + 1 < seg_count; i++) begin
         seg_start[i] = seg_start[i+1];
         seg_size[i] = seg_size[i+1];
         seg_used[i] = seg_used[i+1];
      end
      seg_count--;
      seg_start[seg_count] = '0;
      seg_size[seg_count] = '0;
      seg_used[seg_count] = 0;
      if (cursor >= k && cursor > 0) cursor--;
   endfunction

   function automatic int locate(logic [15:0] off);
      for (int i = 0; i < seg_count; i++)
         if (seg_start[i] == off) return i;
      return seg_count;
   endfunction

   function automatic outcome_t allocator_step(logic [1:0] act, logic [15:0] req,
                                               logic [15:0] off);
      outcome_t r;
      int k;
      bit left, right;
      r = '0;
      if (act == ACT_ALLOC) begin
         k = (req == 0) ? seg_count : choose_segment(req);
         if (k >= seg_count) r.status = ST_NO_FIT;
         else if (seg_size[k] == req) begin
            seg_used[k] = 1;
            holes--;
            used_bytes += req;
            cursor = k;
            r.alloc_offset = seg_start[k];
         end else if (seg_count >= SEGS) r.status = ST_FULL;
         else begin
            for (int i = seg_count; i > k + 1; i--) begin
               seg_start[i] = seg_start[i-1];
               seg_size[i] = seg_size[i-1];
               seg_used[i] = seg_used[i-1];
            end
            seg_start[k+1] = seg_start[k] + req;
            seg_size[k+1] = seg_size[k] - req;
            seg_used[k+1] = 0;
            seg_count++;
            seg_size[k] = req;
            seg_used[k] = 1;
            used_bytes += req;
            cursor = k;
            r.alloc_offset = seg_start[k];
         end
      end else if (act == ACT_FREE) begin
         k = locate(off);
         if (k >= seg_count) r.status = ST_NOT_FND;
         else if (seg_used[k]) begin
            left = k > 0 && !seg_used[k-1];
            right = k + 1 < seg_count && !seg_used[k+1];
            used_bytes -= seg_size[k];
            seg_used[k] = 0;
            holes++;
            if (left) begin
               seg_size[k-1] += seg_size[k];
               drop_segment(k);
               k--;
               holes--;
            end
            if (right) begin
               seg_size[k] += seg_size[k+1];
               drop_segment(k + 1);
               holes--;
            end
         end
      end else if (act == ACT_CHECK) begin
         k = locate(off);
         if (k >= seg_count) r.status = ST_NOT_FND;
         else r.is_allocated = seg_used[k];
      end
      r.allocated_bytes = used_bytes;
      r.hole_count = holes;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch @%0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // result side; during a hold-off the stall stays high throughout
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1;
            @(posedge clock);
         end else begin
            gap = gap_length();
            if (gap > 0) begin
               rsp_stall <= 1;
               repeat (gap) @(posedge clock);
            end
            rsp_stall <= 0;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         outcome_t want;
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected beat, count", results_seen, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_alloc_offset !== want.alloc_offset)
               report_mismatch("alloc_offset", rsp_alloc_offset, want.alloc_offset);
            if (rsp_is_allocated !== want.is_allocated)
               report_mismatch("is_allocated", rsp_is_allocated, want.is_allocated);
            if (rsp_allocated_bytes !== want.allocated_bytes)
               report_mismatch("allocated_bytes", rsp_allocated_bytes,
                               want.allocated_bytes);
            if (rsp_hole_count !== want.hole_count)
               report_mismatch("hole_count", rsp_hole_count, want.hole_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("watchdog expired with %0d results outstanding",
                  pending_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic write_csr(logic idx, logic [15:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      if (idx == CSR_STRATEGY) strategy = data[1:0];
      else begin
         pool_bytes = data;
         rebuild_pool();
      end
   endtask

   // one beat on the request side; known rows also check the typed-in result
   task automatic send_request(logic [1:0] act, logic [15:0] sz, logic [15:0] off,
                               bit known, outcome_t fixed, bit gaps);
      outcome_t r;
      int gap;
      gap = gaps ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_request_size <= sz;
      req_block_offset <= off;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accepted_reqs++;
      r = allocator_step(act, sz, off);
      if (known && r !== fixed) report_mismatch("predictor vs table row", r, fixed);
      pending_results.push_back(r);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      // every accepted request has been answered here; then idle before going on
      repeat (140) @(posedge clock);
   endtask

   function automatic outcome_t res(logic [1:0] s, logic [15:0] a, logic i,
                                    logic [15:0] b, logic [6:0] h);
      return '{s, a, i, b, h};
   endfunction

   // random request favouring offsets that exist in the table
   task automatic random_request(bit gaps);
      logic [1:0] act;
      logic [15:0] sz, off;
      int p;
      p = $urandom_range(0, 99);
      act = (p < 50) ? ACT_ALLOC : (p < 85) ? ACT_FREE : ACT_CHECK;
      p = $urandom_range(0, 99);
      if (p < 70) sz = 16'($urandom_range(1, 64));
      else if (p < 85) sz = 16'($urandom_range(1, pool_bytes > 0 ? pool_bytes : 1));
      else if (p < 95) sz = 16'($urandom);
      else sz = '0;
      if ($urandom_range(0, 9) < 8) off = seg_start[$urandom_range(0, seg_count - 1)];
      else off = 16'($urandom);
      send_request(act, sz, off, 0, '0, gaps);
   endtask

   row_t rows [$];
   logic [15:0] pools [6] = '{16'd1, 16'd0, 16'd65535, 16'd600, 16'd4000, 16'd300};

   initial begin
      row_t row;
      int per_phase, phase;
      repeat (8) @(posedge clock);
      reset <= 0;
      strategy = FIT_FIRST;
      pool_bytes = 16'hFFFF;
      rebuild_pool();

      // directed: reset state, extremes, each action and the no-fit and not-found cases
      rows.push_back('{ACT_CHECK, 16'd0, 16'd0, 1, res(ST_OK, 0, 0, 0, 1)});
      rows.push_back('{ACT_ALLOC, 16'd0, 16'd0, 1, res(ST_NO_FIT, 0, 0, 0, 1)});
      rows.push_back('{ACT_FREE, 16'd0, 16'hFFFF, 1, res(ST_NOT_FND, 0, 0, 0, 1)});
      rows.push_back('{ACT_CHECK, 16'd0, 16'h0001, 1, res(ST_NOT_FND, 0, 0, 0, 1)});
      rows.push_back('{ACT_NONE, 16'hFFFF, 16'hFFFF, 1, res(ST_OK, 0, 0, 0, 1)});
      rows.push_back('{ACT_ALLOC, 16'hFFFF, 16'd0, 1, res(ST_OK, 0, 0, 16'hFFFF, 0)});
      rows.push_back('{ACT_CHECK, 16'd0, 16'd0, 1, res(ST_OK, 0, 1, 16'hFFFF, 0)});
      rows.push_back('{ACT_ALLOC, 16'd1, 16'd0, 1, res(ST_NO_FIT, 0, 0, 16'hFFFF, 0)});
      rows.push_back('{ACT_FREE, 16'd0, 16'd0, 1, res(ST_OK, 0, 0, 0, 1)});
      rows.push_back('{ACT_FREE, 16'd0, 16'd0, 1, res(ST_OK, 0, 0, 0, 1)});
      rows.push_back('{ACT_ALLOC, 16'd100, 16'd0, 0, '0});
      rows.push_back('{ACT_ALLOC, 16'd200, 16'd0, 0, '0});
      rows.push_back('{ACT_ALLOC, 16'd50, 16'd0, 0, '0});
      rows.push_back('{ACT_FREE, 16'd0, 16'd100, 0, '0});
      rows.push_back('{ACT_FREE, 16'd0, 16'd0, 0, '0});
      rows.push_back('{ACT_CHECK, 16'd0, 16'd300, 0, '0});
      rows.push_back('{ACT_FREE, 16'd0, 16'd300, 0, '0});
      foreach (rows[i]) begin
         row = rows[i];
         send_request(row.action, row.size, row.offset, row.known, row.result, 0);
      end
      drain();

      // table-full: 66 one-byte allocations out of a small pool, the last ones finding it full
      write_csr(CSR_POOL, 16'd100);
      for (int i = 0; i < 66; i++) send_request(ACT_ALLOC, 16'd1, 16'd0, 0, '0, 1);
      for (int i = 0; i < 20; i++) random_request(1);
      drain();

      // strategies over several pool sizes, extremes included
      per_phase = N_RANDOM / 12;
      phase = 0;
      for (int s = 0; s < 4; s++) begin
         for (int p = 0; p < 3; p++) begin
            write_csr(CSR_STRATEGY, 16'(s));
            write_csr(CSR_POOL, pools[(s * 3 + p) % 6]);
            if (phase == 5) begin
               // long receiver hold-off while requests keep coming
               fork
                  begin
                     hold_off = 1;
                     repeat (600) @(posedge clock);
                     hold_off = 0;
                  end
                  for (int i = 0; i < 10; i++) random_request(0);
               join
            end
            for (int i = 0; i < per_phase; i++) random_request(1);
            drain();
            phase++;
         end
      end
      // strategy change with a live table
      write_csr(CSR_STRATEGY, 16'(FIT_NEXT));
      write_csr(CSR_POOL, 16'd65535);
      for (int i = 0; i < 40; i++) begin
         random_request(1);
         if (i == 20) begin
            drain();
            write_csr(CSR_STRATEGY, 16'(FIT_WORST));
         end
      end
      drain();

      $display("covered %0d requests, %0d results, all four fit strategies", accepted_reqs,
               results_seen);
      $display("pool sizes 0, 1, small and full range, plus table-full and merges");
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

FILE: filelist.f
hdl/fssa_pkg.sv
hdl/fssa_seg_ram.sv
hdl/fit_strategy_segment_allocator.sv
tb/fit_strategy_segment_allocator_tb.sv
